[rtl/tdmm_pkg.sv]
// Shared constants, register codes and types for the tile darkness mosaic marker.
package tdmm_pkg;

  // Default sizing of the block
  localparam int DEF_MAX_TILE_COLS  = 128;
  localparam int DEF_MAX_IMAGE_SIDE = 4096;

  // Fixed field widths
  localparam int PIX_W       = 8;
  localparam int COORD_W     = 7;
  localparam int SUM_W       = 30;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_MODE  = 3'd5;

  // Register reset values
  localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [6:0]  RST_GRID_COLS    = 7'd20;
  localparam logic [6:0]  RST_GRID_ROWS    = 7'd20;
  localparam logic [7:0]  RST_DARK_THRESH  = 8'd40;

  localparam logic [PIX_W-1:0] WHITE_LEVEL = 8'd255;

  // Settings handed from the setup unit to the datapath
  typedef struct packed {
    logic               busy;
    logic               restart;
    logic               circle_mode;
    logic [COORD_W-1:0] nc;       // clamped tile columns
    logic [COORD_W-1:0] nr;       // clamped tile rows
    logic [COORD_W-1:0] rw;       // width mod columns
    logic [COORD_W-1:0] rh;       // height mod rows
  } ctrl_t;

  // One in-tile pixel with its classification
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               first_row;   // first line of the tile row
    logic               seg_first;   // first pixel of the tile in this line
    logic               seg_last;    // last pixel of the tile in this line
    logic               tile_done;   // last pixel of the tile
    logic               frame_last;  // tile is the last of the frame
    logic               circle_en;   // circle mode and odd checkerboard square
  } item_t;

endpackage

[rtl/tdmm_setup.sv]
// Configuration registers and the derived tile geometry (iterative divider, two products).
module tdmm_setup #(
  parameter int MAX_TILE_COLS  = tdmm_pkg::DEF_MAX_TILE_COLS,
  parameter int MAX_IMAGE_SIDE = tdmm_pkg::DEF_MAX_IMAGE_SIDE
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [tdmm_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [tdmm_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  output tdmm_pkg::ctrl_t                          ctrl_o,
  output logic [$clog2(MAX_IMAGE_SIDE+1)-1:0]      width_o,
  output logic [$clog2(MAX_IMAGE_SIDE+1)-1:0]      height_o,
  output logic [$clog2(MAX_IMAGE_SIDE)-1:0]        tile_w_o,
  output logic [$clog2(MAX_IMAGE_SIDE)-1:0]        tile_h_o,
  output logic [8+2*$clog2(MAX_IMAGE_SIDE)-1:0]    limit_o
);
  import tdmm_pkg::*;

  localparam int SW   = $clog2(MAX_IMAGE_SIDE + 1);
  localparam int PW   = $clog2(MAX_IMAGE_SIDE);
  localparam int NW   = 2 * PW;
  localparam int LW   = 8 + NW;
  localparam int CNTW = $clog2(SW + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD_W = 3'd1;
  localparam logic [2:0] ST_DIV_W  = 3'd2;
  localparam logic [2:0] ST_LOAD_H = 3'd3;
  localparam logic [2:0] ST_DIV_H  = 3'd4;
  localparam logic [2:0] ST_MUL_N  = 3'd5;
  localparam logic [2:0] ST_MUL_L  = 3'd6;

  logic [12:0]        width_q, height_q;
  logic [COORD_W-1:0] cols_q, rows_q;
  logic [7:0]         thr_q;
  logic               circ_q;
  logic               cfg_hit;

  logic [SW-1:0]      w_cl, h_cl;
  logic [COORD_W-1:0] nc_cl, nr_cl;

  logic [2:0]         state_q;
  logic [SW-1:0]      dq_q;
  logic [COORD_W-1:0] rem_q;
  logic [CNTW-1:0]    cnt_q;
  logic [PW-1:0]      tile_w_q, tile_h_q;
  logic [COORD_W-1:0] rw_q, rh_q;
  logic [NW-1:0]      n_q;
  logic [LW-1:0]      limit_q;

  logic [COORD_W-1:0] dvs;
  logic [COORD_W:0]   trial;
  logic               step_bit;
  logic [COORD_W-1:0] step_rem;
  logic [SW-1:0]      step_dq;
  logic [LW-1:0]      mul_a, mul_b;

  // Register index decode
  always_comb begin
    unique case (cfg_idx_i)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_GRID_COLS,
      REG_GRID_ROWS, REG_DARK_THRESH, REG_CIRCLE_MODE: cfg_hit = cfg_we_i;
      default:                                        cfg_hit = 1'b0;
    endcase
  end

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      cols_q   <= RST_GRID_COLS;
      rows_q   <= RST_GRID_ROWS;
      thr_q    <= RST_DARK_THRESH;
      circ_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        REG_GRID_COLS:    cols_q   <= cfg_data_i[COORD_W-1:0];
        REG_GRID_ROWS:    rows_q   <= cfg_data_i[COORD_W-1:0];
        REG_DARK_THRESH:  thr_q    <= cfg_data_i[7:0];
        REG_CIRCLE_MODE:  circ_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp sizes into their legal ranges
  always_comb begin
    if (width_q < 13'd2)                      w_cl = SW'(2);
    else if (32'(width_q) > MAX_IMAGE_SIDE)   w_cl = SW'(MAX_IMAGE_SIDE);
    else                                      w_cl = SW'(width_q);
    if (height_q < 13'd2)                     h_cl = SW'(2);
    else if (32'(height_q) > MAX_IMAGE_SIDE)  h_cl = SW'(MAX_IMAGE_SIDE);
    else                                      h_cl = SW'(height_q);
    if (cols_q < 7'd2)                        nc_cl = 7'd2;
    else if (32'(cols_q) > MAX_TILE_COLS)     nc_cl = COORD_W'(MAX_TILE_COLS);
    else                                      nc_cl = cols_q;
    if (rows_q < 7'd2)                        nr_cl = 7'd2;
    else if (32'(rows_q) > MAX_TILE_COLS)     nr_cl = COORD_W'(MAX_TILE_COLS);
    else                                      nr_cl = rows_q;
  end

  // One restoring division step per cycle
  always_comb begin
    dvs   = (state_q == ST_DIV_H) ? nr_cl : nc_cl;
    trial = {rem_q, dq_q[SW-1]};
    if (trial >= {1'b0, dvs}) begin
      step_bit = 1'b1;
      step_rem = COORD_W'(trial - {1'b0, dvs});
    end else begin
      step_bit = 1'b0;
      step_rem = trial[COORD_W-1:0];
    end
    step_dq = {dq_q[SW-2:0], step_bit};
    mul_a   = LW'(WHITE_LEVEL - thr_q);
    mul_b   = LW'(n_q);
  end

  // Geometry sequencer: divide, divide, tile area, threshold limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD_W;
      cnt_q   <= '0;
    end else if (cfg_hit) begin
      state_q <= ST_LOAD_W;
    end else begin
      unique case (state_q)
        ST_IDLE: ;
        ST_LOAD_W: begin
          cnt_q   <= CNTW'(SW);
          state_q <= ST_DIV_W;
        end
        ST_DIV_W: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNTW'(1)) state_q <= ST_LOAD_H;
        end
        ST_LOAD_H: begin
          cnt_q   <= CNTW'(SW);
          state_q <= ST_DIV_H;
        end
        ST_DIV_H: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNTW'(1)) state_q <= ST_MUL_N;
        end
        ST_MUL_N: state_q <= ST_MUL_L;
        ST_MUL_L: state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  // Divider and product datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_LOAD_W: begin
        dq_q  <= w_cl;
        rem_q <= '0;
      end
      ST_DIV_W: begin
        dq_q  <= step_dq;
        rem_q <= step_rem;
        if (cnt_q == CNTW'(1)) begin
          tile_w_q <= PW'(step_dq);
          rw_q     <= step_rem;
        end
      end
      ST_LOAD_H: begin
        dq_q  <= h_cl;
        rem_q <= '0;
      end
      ST_DIV_H: begin
        dq_q  <= step_dq;
        rem_q <= step_rem;
        if (cnt_q == CNTW'(1)) begin
          tile_h_q <= PW'(step_dq);
          rh_q     <= step_rem;
        end
      end
      ST_MUL_N: n_q     <= NW'(NW'(tile_w_q) * NW'(tile_h_q));
      ST_MUL_L: limit_q <= LW'(mul_a * mul_b);
      default: ;
    endcase
  end

  always_comb begin
    ctrl_o.busy        = (state_q != ST_IDLE);
    ctrl_o.restart     = cfg_hit;
    ctrl_o.circle_mode = circ_q;
    ctrl_o.nc          = nc_cl;
    ctrl_o.nr          = nr_cl;
    ctrl_o.rw          = rw_q;
    ctrl_o.rh          = rh_q;
  end

  assign width_o  = w_cl;
  assign height_o = h_cl;
  assign tile_w_o = tile_w_q;
  assign tile_h_o = tile_h_q;
  assign limit_o  = limit_q;

endmodule

[rtl/tdmm_front.sv]
// Front end: tracks frame position and tile bounds, classifies each accepted pixel.
module tdmm_front #(
  parameter int MAX_IMAGE_SIDE = tdmm_pkg::DEF_MAX_IMAGE_SIDE
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tdmm_pkg::ctrl_t                      ctrl_i,
  input  logic [$clog2(MAX_IMAGE_SIDE+1)-1:0]  width_i,
  input  logic [$clog2(MAX_IMAGE_SIDE+1)-1:0]  height_i,
  input  logic [$clog2(MAX_IMAGE_SIDE)-1:0]    tile_w_i,
  input  logic [$clog2(MAX_IMAGE_SIDE)-1:0]    tile_h_i,
  input  logic                                 pix_valid_i,
  input  logic [tdmm_pkg::PIX_W-1:0]           pixel_i,
  output logic                                 push_o,
  output tdmm_pkg::item_t                      item_o
);
  import tdmm_pkg::*;

  localparam int SW = $clog2(MAX_IMAGE_SIDE + 1);
  localparam int PW = $clog2(MAX_IMAGE_SIDE);
  localparam int EW = SW + 1;

  logic [PW-1:0]      px_q, py_q, cs_q, rs_q;
  logic [COORD_W-1:0] col_q, row_q, crem_q, rrem_q;

  logic [EW-1:0]      col_end, row_end;
  logic               col_in, row_in, col_last, row_last, line_end, frame_end;
  logic [COORD_W:0]   crem_sum, rrem_sum;
  logic               ccarry, rcarry;
  logic [COORD_W-1:0] crem_nxt, rrem_nxt;
  logic [PW-1:0]      cs_nxt, rs_nxt;

  // Tile bounds and position compares
  always_comb begin
    col_end   = EW'(cs_q) + EW'(tile_w_i);
    row_end   = EW'(rs_q) + EW'(tile_h_i);
    col_in    = (col_q < ctrl_i.nc) && (tile_w_i != '0) && (px_q >= cs_q) &&
                (EW'(px_q) < col_end);
    row_in    = (row_q < ctrl_i.nr) && (tile_h_i != '0) && (py_q >= rs_q) &&
                (EW'(py_q) < row_end);
    col_last  = col_in && ((EW'(px_q) + EW'(1)) == col_end);
    row_last  = row_in && ((EW'(py_q) + EW'(1)) == row_end);
    line_end  = (EW'(px_q) + EW'(1)) >= EW'(width_i);
    frame_end = (EW'(py_q) + EW'(1)) >= EW'(height_i);
  end

  // Next tile start: floor((k+1)*W/n) from the running remainder
  always_comb begin
    crem_sum = {1'b0, crem_q} + {1'b0, ctrl_i.rw};
    ccarry   = crem_sum >= {1'b0, ctrl_i.nc};
    crem_nxt = ccarry ? COORD_W'(crem_sum - {1'b0, ctrl_i.nc}) : crem_sum[COORD_W-1:0];
    cs_nxt   = PW'(EW'(cs_q) + EW'(tile_w_i) + EW'(ccarry));
    rrem_sum = {1'b0, rrem_q} + {1'b0, ctrl_i.rh};
    rcarry   = rrem_sum >= {1'b0, ctrl_i.nr};
    rrem_nxt = rcarry ? COORD_W'(rrem_sum - {1'b0, ctrl_i.nr}) : rrem_sum[COORD_W-1:0];
    rs_nxt   = PW'(EW'(rs_q) + EW'(tile_h_i) + EW'(rcarry));
  end

  // Classified pixel for the back end
  always_comb begin
    item_o.pixel      = pixel_i;
    item_o.col        = col_q;
    item_o.row        = row_q;
    item_o.first_row  = (py_q == rs_q);
    item_o.seg_first  = (px_q == cs_q);
    item_o.seg_last   = col_last;
    item_o.tile_done  = col_last && row_last;
    item_o.frame_last = (col_q == ctrl_i.nc - 7'd1) && (row_q == ctrl_i.nr - 7'd1);
    item_o.circle_en  = ctrl_i.circle_mode && (col_q[0] ^ row_q[0]);
  end

  assign push_o = pix_valid_i && col_in && row_in;

  // Position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q   <= '0;
      py_q   <= '0;
      cs_q   <= '0;
      rs_q   <= '0;
      col_q  <= '0;
      row_q  <= '0;
      crem_q <= '0;
      rrem_q <= '0;
    end else if (ctrl_i.restart) begin
      px_q   <= '0;
      py_q   <= '0;
      cs_q   <= '0;
      rs_q   <= '0;
      col_q  <= '0;
      row_q  <= '0;
      crem_q <= '0;
      rrem_q <= '0;
    end else if (pix_valid_i) begin
      if (col_last) begin
        col_q  <= col_q + 7'd1;
        cs_q   <= cs_nxt;
        crem_q <= crem_nxt;
      end
      if (line_end) begin
        px_q   <= '0;
        col_q  <= '0;
        cs_q   <= '0;
        crem_q <= '0;
        if (frame_end) begin
          py_q   <= '0;
          row_q  <= '0;
          rs_q   <= '0;
          rrem_q <= '0;
        end else begin
          py_q <= py_q + PW'(1);
          if (row_last) begin
            row_q  <= row_q + 7'd1;
            rs_q   <= rs_nxt;
            rrem_q <= rrem_nxt;
          end
        end
      end else begin
        px_q <= px_q + PW'(1);
      end
    end
  end

endmodule

[rtl/tdmm_queue.sv]
// Short FIFO of classified pixels between front and back end.
module tdmm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tdmm_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            valid_o,
  output logic            full_o,
  output tdmm_pkg::item_t item_o
);
  import tdmm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t            slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= item_i;
  end

endmodule

[rtl/tdmm_back.sv]
// Back end: per-column sum memory, accumulate stage, threshold compare and output register.
module tdmm_back #(
  parameter int MAX_TILE_COLS  = tdmm_pkg::DEF_MAX_TILE_COLS,
  parameter int MAX_IMAGE_SIDE = tdmm_pkg::DEF_MAX_IMAGE_SIDE
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_valid_i,
  input  tdmm_pkg::item_t                       q_item_i,
  output logic                                  q_pop_o,
  input  logic [8+2*$clog2(MAX_IMAGE_SIDE)-1:0] limit_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [tdmm_pkg::COORD_W-1:0]          cell_col_o,
  output logic [tdmm_pkg::COORD_W-1:0]          cell_row_o,
  output logic                                  square_mark_o,
  output logic                                  circle_mark_o,
  output logic                                  frame_last_o
);
  import tdmm_pkg::*;

  localparam int AW   = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
  localparam int LW   = 8 + 2 * $clog2(MAX_IMAGE_SIDE);
  localparam int CMPW = (LW > SUM_W) ? LW : SUM_W;

  logic [SUM_W-1:0]   sums_mem [MAX_TILE_COLS];
  logic [SUM_W-1:0]   rd_q, acc_q, base, sum;
  item_t              s1_q;
  logic               s1_valid_q, out_valid_q;
  logic               out_free, s1_fire;
  logic               square, circle;
  logic [COORD_W-1:0] col_q, row_q;
  logic               sq_q, ci_q, last_q;

  // Stage handshakes
  assign out_free = !out_valid_q || out_ready_i;
  assign s1_fire  = s1_valid_q && (!s1_q.tile_done || out_free);
  assign q_pop_o  = q_valid_i && (!s1_valid_q || s1_fire);

  // Accumulate and compare against (255 - T) * n
  always_comb begin
    if (s1_q.seg_first) base = s1_q.first_row ? '0 : rd_q;
    else                base = acc_q;
    sum    = base + SUM_W'(s1_q.pixel);
    square = CMPW'(sum) <= CMPW'(limit_i);
    circle = s1_q.circle_en && (CMPW'(sum) < CMPW'(limit_i));
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o)      s1_valid_q <= 1'b1;
      else if (s1_fire) s1_valid_q <= 1'b0;
      if (s1_fire && s1_q.tile_done) out_valid_q <= 1'b1;
      else if (out_ready_i)          out_valid_q <= 1'b0;
    end
  end

  // Column sum memory: read on pop, write back at the end of a line segment
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_q <= q_item_i;
      rd_q <= sums_mem[AW'(q_item_i.col)];
    end
    if (s1_fire) begin
      acc_q <= sum;
      if (s1_q.seg_last && !s1_q.tile_done) sums_mem[AW'(s1_q.col)] <= sum;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_q.tile_done) begin
      col_q  <= s1_q.col;
      row_q  <= s1_q.row;
      sq_q   <= square;
      ci_q   <= circle;
      last_q <= s1_q.frame_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_col_o    = col_q;
  assign cell_row_o    = row_q;
  assign square_mark_o = sq_q;
  assign circle_mark_o = ci_q;
  assign frame_last_o  = last_q;

endmodule

[rtl/tile_darkness_mosaic_marker_top.sv]
// Top level of the tile darkness mosaic marker.
//
// Pixels (8-bit grey, raster order) enter on the s_axis stream, one per beat.
// The frame is cut into grid_cols x grid_rows tiles; for every completed tile
// one beat leaves on m_axis with the tile column/row and the square and circle
// marks; tlast flags the final tile of the frame. Pixels outside any tile
// produce nothing.
// Throughput: one pixel per cycle while s_axis_tready is high, set by the single
// read-modify-write of the per-column sum memory in the back end. The pixel beat
// completing a tile reaches m_axis via the queue slot, stage and output registers.
// Reset and every write to a mapped register restart the frame and rerun the tile
// geometry setup (two serial divisions plus two products); s_axis_tready stays low
// while it runs. Configuration is to be written only while idle; the user must
// ensure this, as the block itself does not enforce it.
// When m_axis stalls, up to four classified pixels queue between front and
// back end, then s_axis_tready drops; no beat is lost.
module tile_darkness_mosaic_marker_top #(
  parameter int MAX_TILE_COLS  = tdmm_pkg::DEF_MAX_TILE_COLS,
  parameter int MAX_IMAGE_SIDE = tdmm_pkg::DEF_MAX_IMAGE_SIDE
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tdmm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tdmm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // [7:0] pixel_value
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [6:0] cell_col, [13:7] cell_row, [14] square_mark, [15] circle_mark
  output logic [15:0]                     m_axis_tdata_o,
  output logic                            m_axis_tlast_o   // frame_last
);
  import tdmm_pkg::*;

  localparam int SW = $clog2(MAX_IMAGE_SIDE + 1);
  localparam int PW = $clog2(MAX_IMAGE_SIDE);
  localparam int LW = 8 + 2 * PW;

  ctrl_t              ctrl;
  logic [SW-1:0]      width, height;
  logic [PW-1:0]      tile_w, tile_h;
  logic [LW-1:0]      limit;
  logic               pix_beat, push, q_valid, q_full, q_pop;
  item_t              push_item, head_item;
  logic [COORD_W-1:0] cell_col, cell_row;
  logic               square_mark, circle_mark;

  assign s_axis_tready_o = !ctrl.busy && !q_full;
  assign pix_beat        = s_axis_tvalid_i && s_axis_tready_o;

  tdmm_setup #(
    .MAX_TILE_COLS (MAX_TILE_COLS),
    .MAX_IMAGE_SIDE(MAX_IMAGE_SIDE)
  ) u_setup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .ctrl_o    (ctrl),
    .width_o   (width),
    .height_o  (height),
    .tile_w_o  (tile_w),
    .tile_h_o  (tile_h),
    .limit_o   (limit)
  );

  tdmm_front #(
    .MAX_IMAGE_SIDE(MAX_IMAGE_SIDE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .width_i    (width),
    .height_i   (height),
    .tile_w_i   (tile_w),
    .tile_h_i   (tile_h),
    .pix_valid_i(pix_beat),
    .pixel_i    (s_axis_tdata_i),
    .push_o     (push),
    .item_o     (push_item)
  );

  tdmm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .full_o (q_full),
    .item_o (head_item)
  );

  tdmm_back #(
    .MAX_TILE_COLS (MAX_TILE_COLS),
    .MAX_IMAGE_SIDE(MAX_IMAGE_SIDE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (head_item),
    .q_pop_o      (q_pop),
    .limit_i      (limit),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .cell_col_o   (cell_col),
    .cell_row_o   (cell_row),
    .square_mark_o(square_mark),
    .circle_mark_o(circle_mark),
    .frame_last_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {circle_mark, square_mark, cell_row, cell_col};

endmodule

[bench/tile_mark_checker.sv]
// Checker for the tile darkness mosaic marker: predicts each tile result and compares it.
`timescale 1ns / 1ps
module tile_mark_checker #(
  parameter int MAX_TILE_COLS  = tdmm_pkg::DEF_MAX_TILE_COLS,
  parameter int MAX_IMAGE_SIDE = tdmm_pkg::DEF_MAX_IMAGE_SIDE
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tdmm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tdmm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  input  logic [7:0]                      s_axis_tdata_i,  // [7:0] pixel_value
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  // [6:0] cell_col, [13:7] cell_row, [14] square_mark, [15] circle_mark
  input  logic [15:0]                     m_axis_tdata_i,
  input  logic                            m_axis_tlast_i,  // frame_last
  output int                              mismatches_o,
  output int                              pending_o,
  output int                              tiles_seen_o,
  output int                              tile_pixels_o
);

  typedef struct packed {
    logic [6:0] col;
    logic [6:0] row;
    logic       square;
    logic       circle;
    logic       last;
  } tile_mark_t;

  // Register copy
  logic [12:0] img_w, img_h;
  logic [6:0]  grid_c, grid_r;
  logic [7:0]  thresh;
  logic        circle_on;

  // Raster position and per-column running sums
  logic [tdmm_pkg::SUM_W-1:0] col_sum [MAX_TILE_COLS];
  logic [12:0] pos_x, pos_y, col_base, row_base;
  logic [7:0]  cur_col, cur_row;

  tile_mark_t pending_tiles [$];
  int errors, tiles, in_tile;

  function automatic int unsigned clip(input int unsigned v, input int unsigned lo,
                                       input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic clear_frame();
    for (int i = 0; i < MAX_TILE_COLS; i++) col_sum[i] = '0;
    pos_x    = '0;
    pos_y    = '0;
    cur_col  = '0;
    cur_row  = '0;
    col_base = '0;
    row_base = '0;
  endtask

  // Register write; an unmapped index changes nothing
  task automatic apply_cfg();
    logic hit;
    hit = 1'b1;
    case (cfg_idx_i)
      tdmm_pkg::REG_IMAGE_WIDTH:  img_w     = cfg_data_i;
      tdmm_pkg::REG_IMAGE_HEIGHT: img_h     = cfg_data_i;
      tdmm_pkg::REG_GRID_COLS:    grid_c    = cfg_data_i[6:0];
      tdmm_pkg::REG_GRID_ROWS:    grid_r    = cfg_data_i[6:0];
      tdmm_pkg::REG_DARK_THRESH:  thresh    = cfg_data_i[7:0];
      tdmm_pkg::REG_CIRCLE_MODE:  circle_on = cfg_data_i[0];
      default:                    hit       = 1'b0;
    endcase
    if (hit) clear_frame();
  endtask

  // Advance the raster by one pixel and queue a tile result when a tile completes
  task automatic step_grid(input logic [7:0] pix);
    int unsigned w, h, nc, nr, tw, th, c, r;
    logic row_in, col_in, row_last, col_last;
    logic [tdmm_pkg::SUM_W-1:0] acc;
    longint unsigned limit;
    tile_mark_t res;
    w  = clip(32'(img_w), 2, MAX_IMAGE_SIDE);
    h  = clip(32'(img_h), 2, MAX_IMAGE_SIDE);
    nc = clip(32'(grid_c), 2, MAX_TILE_COLS);
    nr = clip(32'(grid_r), 2, MAX_TILE_COLS);
    tw = w / nc;
    th = h / nr;
    c  = 32'(cur_col);
    r  = 32'(cur_row);
    row_in = (r < nr) && (th > 0) && (pos_y >= row_base) && (pos_y < row_base + th);
    col_in = (c < nc) && (c < MAX_TILE_COLS) && (tw > 0) &&
             (pos_x >= col_base) && (pos_x < col_base + tw);
    row_last = row_in && (pos_y == row_base + th - 1);
    if (col_in) begin
      col_last = (pos_x == col_base + tw - 1);
      if (row_in) begin
        acc = col_sum[c] + {22'd0, pix};
        col_sum[c] = acc;
        in_tile++;
        if (col_last && row_last) begin
          // mean compare without division: sum against (255 - T) * n
          limit = 64'(8'd255 - thresh);
          limit = limit * 64'(tw) * 64'(th);
          res.col    = c[6:0];
          res.row    = r[6:0];
          res.square = (acc <= limit);
          res.circle = circle_on && ((r + c) % 2 == 1) && (acc < limit);
          res.last   = (c == nc - 1) && (r == nr - 1);
          pending_tiles = {pending_tiles, res};
          col_sum[c] = '0;
        end
      end
      if (col_last) begin
        cur_col  = 8'(c + 1);
        col_base = 13'(((c + 1) * w) / nc);
      end
    end
    // line wrap and frame end
    if (pos_x + 1 >= w) begin
      pos_x    = '0;
      cur_col  = '0;
      col_base = '0;
      if (row_last) begin
        cur_row  = 8'(r + 1);
        row_base = 13'(((r + 1) * h) / nr);
      end
      if (pos_y + 1 >= h) clear_frame();
      else pos_y = pos_y + 13'd1;
    end else begin
      pos_x = pos_x + 13'd1;
    end
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endtask

  task automatic check_tile();
    tile_mark_t want;
    if (pending_tiles.size() == 0) begin
      errors++;
      $display("%0t: tile beat with none expected, expected nothing, got data %h last %b",
               $time, m_axis_tdata_i, m_axis_tlast_i);
    end else begin
      want = pending_tiles.pop_front();
      tiles++;
      check_field("cell_col", want.col, m_axis_tdata_i[6:0]);
      check_field("cell_row", want.row, m_axis_tdata_i[13:7]);
      check_field("square_mark", want.square, m_axis_tdata_i[14]);
      check_field("circle_mark", want.circle, m_axis_tdata_i[15]);
      check_field("frame_last", want.last, m_axis_tlast_i);
    end
  endtask

  // Sample both streams and the write port at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w     = tdmm_pkg::RST_IMAGE_WIDTH;
      img_h     = tdmm_pkg::RST_IMAGE_HEIGHT;
      grid_c    = tdmm_pkg::RST_GRID_COLS;
      grid_r    = tdmm_pkg::RST_GRID_ROWS;
      thresh    = tdmm_pkg::RST_DARK_THRESH;
      circle_on = 1'b0;
      clear_frame();
      pending_tiles.delete();
      errors  = 0;
      tiles   = 0;
      in_tile = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_tile();
      if (cfg_we_i) apply_cfg();
      if (s_axis_tvalid_i && s_axis_tready_i) step_grid(s_axis_tdata_i);
    end
    mismatches_o  <= errors;
    pending_o     <= pending_tiles.size();
    tiles_seen_o  <= tiles;
    tile_pixels_o <= in_tile;
  end

endmodule

[bench/tile_darkness_mosaic_marker_top_tb.sv]
// Testbench top: pixel and register stimulus for the tile darkness mosaic marker, and verdict.
`timescale 1ns / 1ps
module tile_darkness_mosaic_marker_top_tb;

  localparam logic [tdmm_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [tdmm_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES  = 12;
  localparam int RANDOM_PIXELS = 700;
  localparam int WIDE_PIXELS   = 300;
  localparam int HOLD_CYCLES   = 400;

  localparam int PIX_RANDOM  = 0;
  localparam int PIX_EXTREME = 1;
  localparam int PIX_EDGE    = 2;
  localparam int PIX_NEAR    = 3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                            cfg_we;
  logic [tdmm_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [tdmm_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [7:0]                      s_tdata;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [15:0]                     m_tdata;
  logic                            m_tlast;

  int mismatches, pending, tiles_seen, tile_pixels;
  int burst_left    = 0;
  int pix_sent      = 0;
  int settings_used = 0;
  int next_hold     = 30;

  always #5 clk_i = ~clk_i;

  tile_darkness_mosaic_marker_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  tile_mark_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .tiles_seen_o    (tiles_seen),
    .tile_pixels_o   (tile_pixels)
  );

  // Watchdog
  initial begin
    #10_000_000;
    $display("%0t: run timed out", $time);
    $display("RESULT: ERROR");
    $finish;
  end

  // One pixel beat; bursts of random length separated by random gaps
  task automatic send_pixel(input logic [7:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 250)
                                                : $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk_i); while (!s_tready);
    burst_left--;
    pix_sent++;
  endtask

  // Stop sending and wait until every expected tile has left, plus pipeline slack
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [tdmm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tdmm_pkg::CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  // Full register setup while idle; optionally a write to an unmapped index too
  task automatic set_geometry(input logic [12:0] w, input logic [12:0] h,
                              input logic [6:0] gc, input logic [6:0] gr,
                              input logic [7:0] th, input logic cm, input bit spare);
    settle();
    cfg_write(tdmm_pkg::REG_IMAGE_WIDTH, w);
    cfg_write(tdmm_pkg::REG_IMAGE_HEIGHT, h);
    cfg_write(tdmm_pkg::REG_GRID_COLS, 13'(gc));
    cfg_write(tdmm_pkg::REG_GRID_ROWS, 13'(gr));
    cfg_write(tdmm_pkg::REG_DARK_THRESH, 13'(th));
    cfg_write(tdmm_pkg::REG_CIRCLE_MODE, 13'(cm));
    if (spare) cfg_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 13'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [6:0] grid_pick(input int side);
    int sel, hi;
    sel = $urandom_range(0, 9);
    hi  = (side > 127) ? 127 : side;
    if (sel == 0) return 7'($urandom_range(0, 1));
    if (sel == 1) return 7'((side + 4 > 127) ? 127 : $urandom_range(side + 1, side + 4));
    return 7'($urandom_range(2, hi));
  endfunction

  function automatic logic [7:0] pixel_pick(input int mode, input int lvl);
    int v, sel;
    case (mode)
      PIX_RANDOM:  v = $urandom_range(0, 255);
      PIX_EXTREME: v = $urandom_range(0, 1) ? 255 : 0;
      PIX_EDGE: begin
        // mostly right at the threshold level so sums land on the limit
        sel = $urandom_range(0, 5);
        v = lvl + ((sel == 0) ? -1 : (sel == 5) ? 1 : 0);
      end
      default: begin
        v = $urandom_range(0, 40);
        v = lvl + v - 20;
      end
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Result side: changing ready patterns, plus two long hold-offs
  initial begin : tile_sink
    int mode, span, tick;
    m_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (tick = 0; tick < span; tick++) begin
        if (tiles_seen >= next_hold) begin
          m_tready <= 1'b0;
          next_hold = (next_hold < 200) ? 200 : 32'h7fff_ffff;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 9) != 0);
          default: m_tready <= (tick % 4 == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : pixel_source
    int x, y, k, n, w_eff, h_eff, mode, start_pix, left, lingering;
    logic [12:0] w, h;
    logic [6:0]  gc, gr;
    logic [7:0]  th, v;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: far from any tile end, nothing expected
    for (k = 0; k < 40; k++) send_pixel(8'($urandom_range(0, 255)));

    // 4x4 frame, 2x2 tiles: threshold 0, 255 and mid, with sums on the limit
    for (k = 0; k < 3; k++) begin
      th = (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'd100;
      set_geometry(13'd4, 13'd4, 7'd2, 7'd2, th, 1'b1, 1'b0);
      for (y = 0; y < 4; y++) begin
        for (x = 0; x < 4; x++) begin
          case (k)
            0:       v = (x / 2 == 1) ? 8'd0 : 8'd255;
            1:       v = (x == 3 && y == 3) ? 8'd1 : 8'd0;
            default: v = (x == 2 && y == 0) ? 8'd154 : (x == 0 && y == 3) ? 8'd156 : 8'd155;
          endcase
          send_pixel(v);
          // unmapped register writes mid-frame must not restart it
          if (k == 1 && y == 1 && x == 1) begin
            settle();
            cfg_write(REG_SPARE_LO, 13'($urandom));
            cfg_write(REG_SPARE_HI, 13'($urandom));
            cfg_we <= 1'b0;
          end
        end
      end
    end

    // sizes below range clamp to a 2x2 frame of single-pixel tiles
    set_geometry(13'd0, 13'd1, 7'd0, 7'd1, 8'd128, 1'b1, 1'b0);
    for (k = 0; k < 8; k++) send_pixel(8'($urandom_range(0, 255)));

    // more tile columns than pixels: no tile ever completes
    set_geometry(13'd3, 13'd2, 7'd5, 7'd2, 8'd40, 1'b0, 1'b0);
    for (k = 0; k < 12; k++) send_pixel(8'($urandom_range(0, 255)));

    // widest line (clamped) with the most columns; pause mid-line until drained
    set_geometry(13'd8191, 13'd2, 7'd127, 7'd2, 8'd128, 1'b1, 1'b0);
    for (k = 0; k < WIDE_PIXELS; k++) begin
      if (k == WIDE_PIXELS / 2) settle();
      send_pixel(pixel_pick(PIX_EXTREME, 0));
    end

    // tallest frame (clamped) with the most rows
    set_geometry(13'd2, 13'd8191, 7'd2, 7'd127, 8'd200, 1'b0, 1'b0);
    for (k = 0; k < 260; k++) send_pixel(8'($urandom_range(0, 255)));

    // random geometries, mostly whole frames
    start_pix = pix_sent;
    while (pix_sent - start_pix < RANDOM_PIXELS) begin
      k = $urandom_range(0, 19);
      if (k < 2) begin
        w = 13'($urandom_range(100, 300));
        h = 13'($urandom_range(2, 3));
      end else begin
        w = (k == 2) ? 13'($urandom_range(0, 1)) : 13'($urandom_range(2, 24));
        h = (k == 3) ? 13'($urandom_range(0, 1)) : 13'($urandom_range(2, 16));
      end
      w_eff = (w < 13'd2) ? 2 : int'(w);
      h_eff = (h < 13'd2) ? 2 : int'(h);
      gc = grid_pick(w_eff);
      gr = grid_pick(h_eff);
      k  = $urandom_range(0, 7);
      th = (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'($urandom_range(0, 255));
      set_geometry(w, h, gc, gr, th, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
      mode = $urandom_range(0, 3);
      n = w_eff * h_eff;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : n * $urandom_range(1, 2);
      left = RANDOM_PIXELS - (pix_sent - start_pix);
      if (n > left) n = left;
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 299) == 0) settle();
        send_pixel(pixel_pick(mode, 255 - int'(th)));
      end
    end

    // drain, bounded
    s_tvalid <= 1'b0;
    lingering = 0;
    while (pending != 0 && lingering < 20000) begin
      @(posedge clk_i);
      lingering++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending != 0) begin
      $display("%0t: expected %0d more tile results, got none", $time, pending);
    end
    $display("Sent %0d pixel beats (%0d inside tiles) over %0d register setups;",
             pix_sent, tile_pixels, settings_used);
    $display("compared %0d tile results, %0d mismatches.", tiles_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
